// File: sv/sbu_pkg.sv
// ----------------------------------------------------------------------------
// sbu_pkg
// Shared types and constants for the stroke sample bounds union block.
// ----------------------------------------------------------------------------
package sbu_pkg;

  localparam int unsigned COORD_W  = 16;   // sample position and radius width
  localparam int unsigned EDGE_W   = 12;   // result edge width
  localparam int unsigned HIGH_W   = 13;   // exclusive edge may reach 4096
  localparam int unsigned RADIUS_W = 13;   // radius in sample units, up to 4096
  localparam int unsigned PIX_SHIFT = 4;   // sixteen sample units per pixel
  localparam logic [RADIUS_W-1:0] MIN_RADIUS_UNITS = RADIUS_W'(24);
  localparam logic [4:0] ROUND_UP = 5'd15;

  // rectangle of one sample
  typedef struct packed {
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [HIGH_W-1:0] right;
    logic [HIGH_W-1:0] bottom;
    logic              bad;
  } rect_t;

  // control from the input stage to the accumulator
  typedef struct packed {
    logic upd;
    logic last;
  } acc_ctrl_t;

endpackage

// File: sv/sbu_if.sv
// ----------------------------------------------------------------------------
// sbu interfaces
// Valid/ready channels for brush samples and union rectangles.
// ----------------------------------------------------------------------------
interface sbu_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_sample;
  logic [15:0] y_sample;
  logic [15:0] radius_fine;
  logic        last_sample;

  modport source (output valid, x_sample, y_sample, radius_fine, last_sample,
                  input ready);
  modport sink (input valid, x_sample, y_sample, radius_fine, last_sample,
                output ready);
endinterface

interface sbu_rect_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_edge;
  logic [11:0] top_edge;
  logic [11:0] right_edge;
  logic [11:0] bottom_edge;
  logic        invalid_operation;

  modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                  invalid_operation, input ready);
  modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                invalid_operation, output ready);
endinterface

// File: sv/sbu_rect_calc.sv
// ----------------------------------------------------------------------------
// sbu_rect_calc
// Converts one brush sample into its clamped pixel rectangle.
// ----------------------------------------------------------------------------
module sbu_rect_calc #(
  parameter int unsigned WORLD_WIDTH  = 2048,
  parameter int unsigned WORLD_HEIGHT = 2048
) (
  input  logic [sbu_pkg::COORD_W-1:0] x_i,
  input  logic [sbu_pkg::COORD_W-1:0] y_i,
  input  logic [sbu_pkg::COORD_W-1:0] radius_i,
  output sbu_pkg::rect_t              rect_o
);

  localparam logic [sbu_pkg::COORD_W:0] XLimit =
    (sbu_pkg::COORD_W+1)'(WORLD_WIDTH << sbu_pkg::PIX_SHIFT);
  localparam logic [sbu_pkg::COORD_W:0] YLimit =
    (sbu_pkg::COORD_W+1)'(WORLD_HEIGHT << sbu_pkg::PIX_SHIFT);
  localparam logic [sbu_pkg::HIGH_W-1:0] WLimit = sbu_pkg::HIGH_W'(WORLD_WIDTH);
  localparam logic [sbu_pkg::HIGH_W-1:0] HLimit = sbu_pkg::HIGH_W'(WORLD_HEIGHT);

  function automatic logic [sbu_pkg::EDGE_W-1:0] low_edge(
    input logic [sbu_pkg::COORD_W-1:0] pos,
    input logic [sbu_pkg::RADIUS_W-1:0] rad
  );
    logic [sbu_pkg::COORD_W-1:0] base;
    base = (pos > sbu_pkg::COORD_W'(rad)) ? pos - sbu_pkg::COORD_W'(rad) : '0;
    return base[sbu_pkg::COORD_W-1 -: sbu_pkg::EDGE_W];
  endfunction

  function automatic logic [sbu_pkg::HIGH_W-1:0] high_edge(
    input logic [sbu_pkg::COORD_W-1:0] pos,
    input logic [sbu_pkg::RADIUS_W-1:0] rad,
    input logic [sbu_pkg::HIGH_W-1:0]   limit
  );
    logic [sbu_pkg::COORD_W+1:0] sum;
    logic [sbu_pkg::COORD_W-3:0] e;
    sum = (sbu_pkg::COORD_W+2)'(pos) + (sbu_pkg::COORD_W+2)'(rad)
        + (sbu_pkg::COORD_W+2)'(sbu_pkg::ROUND_UP);
    e = sum[sbu_pkg::COORD_W+1:sbu_pkg::PIX_SHIFT];
    return (e < (sbu_pkg::COORD_W-2)'(limit)) ? sbu_pkg::HIGH_W'(e) : limit;
  endfunction

  logic [sbu_pkg::COORD_W:0]   rad_sum;
  logic [sbu_pkg::RADIUS_W-1:0] rad_raw;
  logic [sbu_pkg::RADIUS_W-1:0] rad_units;

  // round the fine radius up to sample units, then apply the minimum
  assign rad_sum   = (sbu_pkg::COORD_W+1)'(radius_i)
                   + (sbu_pkg::COORD_W+1)'(sbu_pkg::ROUND_UP);
  assign rad_raw   = rad_sum[sbu_pkg::COORD_W:sbu_pkg::PIX_SHIFT];
  assign rad_units = (rad_raw < sbu_pkg::MIN_RADIUS_UNITS) ? sbu_pkg::MIN_RADIUS_UNITS
                                                          : rad_raw;

  assign rect_o.left   = low_edge(x_i, rad_units);
  assign rect_o.top    = low_edge(y_i, rad_units);
  assign rect_o.right  = high_edge(x_i, rad_units, WLimit);
  assign rect_o.bottom = high_edge(y_i, rad_units, HLimit);
  assign rect_o.bad    = ((sbu_pkg::COORD_W+1)'(x_i) > XLimit)
                      || ((sbu_pkg::COORD_W+1)'(y_i) > YLimit)
                      || (radius_i == '0);

endmodule

// File: sv/sbu_union_acc.sv
// ----------------------------------------------------------------------------
// sbu_union_acc
// Running union of sample rectangles and the result register.
// ----------------------------------------------------------------------------
module sbu_union_acc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbu_pkg::acc_ctrl_t ctrl_i,
  input  sbu_pkg::rect_t    rect_i,
  output logic              res_free_o,
  sbu_rect_if.source        rect_o
);

  logic [sbu_pkg::EDGE_W-1:0] left_q, top_q, left_d, top_d;
  logic [sbu_pkg::HIGH_W-1:0] right_q, bottom_q, right_d, bottom_d;
  logic                       have_q, inv_q, have_d, inv_d;

  logic                       res_valid_q;
  logic [sbu_pkg::EDGE_W-1:0] res_left_q, res_top_q, res_right_q, res_bottom_q;
  logic                       res_inv_q;

  assign res_free_o = !res_valid_q || rect_o.ready;

  // merged union including the current sample
  always_comb begin
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    have_d   = have_q || !rect_i.bad;
    inv_d    = inv_q || rect_i.bad;
    if (!rect_i.bad) begin
      if (!have_q) begin
        left_d   = rect_i.left;
        top_d    = rect_i.top;
        right_d  = rect_i.right;
        bottom_d = rect_i.bottom;
      end else begin
        if (rect_i.left < left_q)     left_d   = rect_i.left;
        if (rect_i.top < top_q)       top_d    = rect_i.top;
        if (rect_i.right > right_q)   right_d  = rect_i.right;
        if (rect_i.bottom > bottom_q) bottom_d = rect_i.bottom;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      have_q   <= 1'b0;
      inv_q    <= 1'b0;
    end else if (ctrl_i.upd) begin
      if (ctrl_i.last) begin
        left_q   <= '0;
        top_q    <= '0;
        right_q  <= '0;
        bottom_q <= '0;
        have_q   <= 1'b0;
        inv_q    <= 1'b0;
      end else begin
        left_q   <= left_d;
        top_q    <= top_d;
        right_q  <= right_d;
        bottom_q <= bottom_d;
        have_q   <= have_d;
        inv_q    <= inv_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctrl_i.upd && ctrl_i.last) begin
      res_valid_q <= 1'b1;
    end else if (rect_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && ctrl_i.last) begin
      res_inv_q <= inv_d;
      if (inv_d) begin
        res_left_q   <= '0;
        res_top_q    <= '0;
        res_right_q  <= '0;
        res_bottom_q <= '0;
      end else begin
        res_left_q   <= left_d;
        res_top_q    <= top_d;
        res_right_q  <= right_d[sbu_pkg::EDGE_W-1:0];
        res_bottom_q <= bottom_d[sbu_pkg::EDGE_W-1:0];
      end
    end
  end

  assign rect_o.valid             = res_valid_q;
  assign rect_o.left_edge         = res_left_q;
  assign rect_o.top_edge          = res_top_q;
  assign rect_o.right_edge        = res_right_q;
  assign rect_o.bottom_edge       = res_bottom_q;
  assign rect_o.invalid_operation = res_inv_q;

endmodule

// File: sv/stroke_sample_bounds_union.sv
// ----------------------------------------------------------------------------
// stroke_sample_bounds_union
// Bounding-box union of the brush samples of one stroke operation.
// ----------------------------------------------------------------------------
// usage:
//   sample_i takes brush samples (x, y in 1/16 pixel, radius in 1/256 units,
//   last flag) under valid/ready. rect_o gives one union rectangle per
//   operation, on the sample flagged last, under valid/ready.
//   a sample is registered at the input, turned into a pixel rectangle and
//   merged into the running union as it leaves the input register; the union
//   of a finished operation lands in the result register at that same edge.
//   throughput is one sample per cycle while no last sample waits for the
//   result register; samples that are not last never wait on the output
//   side.
//   when the result register is still full and not taken, a last sample
//   waits in the input register and sample_i.ready drops until rect_o frees.
//   any sample with zero radius or a position beyond the world marks the
//   operation invalid: edges read zero and invalid_operation is set.
//   reset empties both registers and clears the union.
// ----------------------------------------------------------------------------
module stroke_sample_bounds_union #(
  parameter int unsigned WORLD_WIDTH  = 2048,
  parameter int unsigned WORLD_HEIGHT = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbu_sample_if.sink sample_i,
  sbu_rect_if.source rect_o
);

  logic                        in_valid_q;
  logic [sbu_pkg::COORD_W-1:0] x_q, y_q, radius_q;
  logic                        last_q;
  logic                        advance;
  logic                        res_free;
  logic                        accept;
  sbu_pkg::acc_ctrl_t          ctrl;
  sbu_pkg::rect_t              rect;

  // a last request needs a free result register to move on
  assign advance        = in_valid_q && (!last_q || res_free);
  assign sample_i.ready = !in_valid_q || advance;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= sample_i.x_sample;
      y_q      <= sample_i.y_sample;
      radius_q <= sample_i.radius_fine;
      last_q   <= sample_i.last_sample;
    end
  end

  sbu_rect_calc #(
    .WORLD_WIDTH (WORLD_WIDTH),
    .WORLD_HEIGHT(WORLD_HEIGHT)
  ) u_rect_calc (
    .x_i     (x_q),
    .y_i     (y_q),
    .radius_i(radius_q),
    .rect_o  (rect)
  );

  assign ctrl.upd  = advance;
  assign ctrl.last = last_q;

  sbu_union_acc u_union_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rect_i    (rect),
    .res_free_o(res_free),
    .rect_o    (rect_o)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the brush sample bounding-box union: samples go in under valid/ready
// with random gaps, each union rectangle coming out is compared with a model
// of the pixel rectangle arithmetic kept alongside the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WORLD_W       = 2048;
  localparam int unsigned WORLD_H       = 2048;
  localparam int unsigned UNITS_PER_PIX = 16;
  localparam int unsigned FINE_ROUND    = 15;   // rounds 1/256 units up to 1/16
  localparam int unsigned FINE_PER_UNIT = 16;
  localparam int unsigned MIN_RU        = 24;
  localparam int unsigned MAX_GAP       = 14;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [sbu_pkg::COORD_W-1:0] x;
    logic [sbu_pkg::COORD_W-1:0] y;
    logic [sbu_pkg::COORD_W-1:0] r;
    logic                        last;
  } brush_t;

  typedef struct packed {
    logic [sbu_pkg::EDGE_W-1:0] left;
    logic [sbu_pkg::EDGE_W-1:0] top;
    logic [sbu_pkg::EDGE_W-1:0] right;
    logic [sbu_pkg::EDGE_W-1:0] bottom;
    logic                       invalid;
  } box_t;

  class bounds_scoreboard;
    box_t        expected_boxes[$];
    int unsigned box_left, box_top, box_right, box_bottom;
    bit          have_box, saw_bad;
    int unsigned n_samples, n_ops, n_bad_ops, n_checked, n_errors;

    function int unsigned low_edge(int unsigned pos, int unsigned ru);
      return (pos > ru) ? (pos - ru) / UNITS_PER_PIX : 0;
    endfunction

    function int unsigned high_edge(int unsigned pos, int unsigned ru, int unsigned lim);
      int unsigned e;
      e = (pos + ru + UNITS_PER_PIX - 1) / UNITS_PER_PIX;
      return (e < lim) ? e : lim;
    endfunction

    // accepted sample: merge its rectangle, close the operation on last
    function void note_sample(brush_t s);
      int unsigned px, py, pr, ru, l, t, rt, b;
      box_t        res;
      px = s.x;
      py = s.y;
      pr = s.r;
      n_samples++;
      if (px > WORLD_W * UNITS_PER_PIX || py > WORLD_H * UNITS_PER_PIX || pr == 0) begin
        saw_bad = 1'b1;
      end else begin
        ru = (pr + FINE_ROUND) / FINE_PER_UNIT;
        if (ru < MIN_RU) ru = MIN_RU;
        l  = low_edge(px, ru);
        t  = low_edge(py, ru);
        rt = high_edge(px, ru, WORLD_W);
        b  = high_edge(py, ru, WORLD_H);
        if (!have_box) begin
          box_left   = l;
          box_top    = t;
          box_right  = rt;
          box_bottom = b;
          have_box   = 1'b1;
        end else begin
          if (l < box_left) box_left = l;
          if (t < box_top) box_top = t;
          if (rt > box_right) box_right = rt;
          if (b > box_bottom) box_bottom = b;
        end
      end
      if (s.last) begin
        if (saw_bad) begin
          res = '{left: '0, top: '0, right: '0, bottom: '0, invalid: 1'b1};
          n_bad_ops++;
        end else begin
          res.left    = sbu_pkg::EDGE_W'(box_left);
          res.top     = sbu_pkg::EDGE_W'(box_top);
          res.right   = sbu_pkg::EDGE_W'(box_right);
          res.bottom  = sbu_pkg::EDGE_W'(box_bottom);
          res.invalid = 1'b0;
        end
        expected_boxes.push_back(res);
        n_ops++;
        box_left   = 0;
        box_top    = 0;
        box_right  = 0;
        box_bottom = 0;
        have_box   = 1'b0;
        saw_bad    = 1'b0;
      end
    endfunction

    function void check_rect(box_t got);
      box_t exp_box;
      n_checked++;
      if (expected_boxes.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result l=%0d t=%0d r=%0d b=%0d inv=%0b", $time,
                   got.left, got.top, got.right, got.bottom, got.invalid);
        return;
      end
      exp_box = expected_boxes.pop_front();
      if (got.left != exp_box.left || got.top != exp_box.top ||
          got.right != exp_box.right || got.bottom != exp_box.bottom ||
          got.invalid != exp_box.invalid) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch: expected l=%0d t=%0d r=%0d b=%0d inv=%0b", $time,
                   exp_box.left, exp_box.top, exp_box.right, exp_box.bottom,
                   exp_box.invalid);
          $display("[%0t]           actual   l=%0d t=%0d r=%0d b=%0d inv=%0b", $time,
                   got.left, got.top, got.right, got.bottom, got.invalid);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_boxes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sbu_sample_if smp ();
  sbu_rect_if   rsp ();

  bounds_scoreboard sb = new();

  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_hold_req;
  int unsigned longest_hold;
  int unsigned stall_cycles;

  stroke_sample_bounds_union #(
    .WORLD_WIDTH  (WORLD_W),
    .WORLD_HEIGHT (WORLD_H)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp.sink),
    .rect_o   (rsp.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---- request driver ----

  function automatic brush_t mk(int unsigned x, int unsigned y, int unsigned r, bit last);
    brush_t s;
    s.x    = sbu_pkg::COORD_W'(x);
    s.y    = sbu_pkg::COORD_W'(y);
    s.r    = sbu_pkg::COORD_W'(r);
    s.last = last;
    return s;
  endfunction

  function automatic int unsigned rand_coord(int unsigned lim);
    case ($urandom_range(0, 29))
      0:       return $urandom_range(0, 16'hFFFF);           // may lie beyond the world
      1, 2:    return $urandom_range(0, 400);
      3, 4:    return $urandom_range(lim - 400, lim);
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  function automatic int unsigned rand_radius();
    case ($urandom_range(0, 59))
      0:          return 0;
      1, 2, 3, 4: return $urandom_range(1, 400);               // up to 400, mostly below the minimum
      5, 6:       return $urandom_range(1, 16'hFFFF);
      default:    return $urandom_range(1, 8000);
    endcase
  endfunction

  task automatic send_sample(brush_t s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid       <= 1'b1;
    smp.x_sample    <= s.x;
    smp.y_sample    <= s.y;
    smp.radius_fine <= s.r;
    smp.last_sample <= s.last;
    @(posedge clk_i);
    while (!smp.ready) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    sb.note_sample(s);
  endtask

  task automatic run_ops(int unsigned n_items, int unsigned max_len);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      if (max_len > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(9, 24);
      for (int unsigned i = 0; i < len; i++)
        send_sample(mk(rand_coord(WORLD_W * UNITS_PER_PIX),
                       rand_coord(WORLD_H * UNITS_PER_PIX), rand_radius(), i == len - 1));
      sent += len;
    end
  endtask

  task automatic wait_drained();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // ---- result receiver ----

  initial begin : rx_side
    int unsigned hold_left;
    box_t        got;
    hold_left = 0;
    rsp.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        got.left    = rsp.left_edge;
        got.top     = rsp.top_edge;
        got.right   = rsp.right_edge;
        got.bottom  = rsp.bottom_edge;
        got.invalid = rsp.invalid_operation;
        sb.check_rect(got);
        hold_left = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > longest_hold) longest_hold = hold_left;
      if (hold_left != 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // ---- stimulus ----

  initial begin : tx_side
    smp.valid       <= 1'b0;
    smp.x_sample    <= '0;
    smp.y_sample    <= '0;
    smp.radius_fine <= '0;
    smp.last_sample <= 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_hold_req  = 0;
    longest_hold = 0;
    stall_cycles = 0;
    wait (rst_ni);
    @(posedge clk_i);

    // corners of the world, clamps and the minimum radius
    send_sample(mk(0, 0, 1, 1));
    send_sample(mk(32768, 32768, 65535, 1));
    send_sample(mk(32767, 32767, 65535, 1));
    send_sample(mk(24, 25, 368, 1));
    send_sample(mk(40, 1000, 369, 1));
    send_sample(mk(32000, 100, 385, 1));
    send_sample(mk(1000, 32760, 16, 1));
    // out-of-world positions and zero radius
    send_sample(mk(32769, 100, 100, 1));
    send_sample(mk(100, 32769, 100, 1));
    send_sample(mk(65535, 65535, 65535, 1));
    send_sample(mk(100, 100, 0, 1));
    // union over several samples
    send_sample(mk(1000, 2000, 500, 0));
    send_sample(mk(30000, 500, 2000, 0));
    send_sample(mk(16000, 16000, 65535, 1));
    // a bad sample in the middle spoils the whole operation
    send_sample(mk(5000, 5000, 1000, 0));
    send_sample(mk(5000, 5000, 0, 0));
    send_sample(mk(6000, 6000, 1000, 1));
    // bad sample first, good ones after
    send_sample(mk(40000, 100, 100, 0));
    send_sample(mk(100, 100, 100, 0));
    send_sample(mk(200, 300, 4000, 1));

    run_ops(600, 8);

    // output held off while single-sample requests keep coming back to back
    tx_idle     = 1'b0;
    rx_hold_req = LONG_HOLD;
    run_ops(60, 1);
    wait_drained();

    rx_idle = 1'b0;
    run_ops(450, 8);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_ops(520, 8);

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("covered %0d samples in %0d operations, %0d of them invalid; %0d results checked",
             sb.n_samples, sb.n_ops, sb.n_bad_ops, sb.n_checked);
    $display("longest output hold-off %0d cycles, input stalled on %0d cycles",
             longest_hold, stall_cycles);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", sb.n_errors, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sbu_pkg.sv
sv/sbu_if.sv
sv/sbu_rect_calc.sv
sv/sbu_union_acc.sv
sv/stroke_sample_bounds_union.sv
dv/tb_top.sv
